/* rtl/core/mfbd_pkg.sv */
// shared types, codes and classification for the mpeg-4 frame boundary detector
package mfbd_pkg;

    // byte offset counter width default
    localparam int OFFSET_WIDTH_DEF = 32;
    // width of the reported start offset field
    localparam int START_OFFSET_W = 32;

    // start code classes as reported on code_class
    typedef enum logic [2:0] {
        CLASS_VOS   = 3'd0,
        CLASS_VO    = 3'd1,
        CLASS_VOL   = 3'd2,
        CLASS_GOV   = 3'd3,
        CLASS_VOP   = 3'd4,
        CLASS_USER  = 3'd5,
        CLASS_OTHER = 3'd6
    } class_t;

    // header layer rank, sync ranks highest
    typedef enum logic [2:0] {
        LAYER_VOS  = 3'd1,
        LAYER_VO   = 3'd2,
        LAYER_VOL  = 3'd3,
        LAYER_GOV  = 3'd4,
        LAYER_VOP  = 3'd5,
        LAYER_SYNC = 3'd6
    } layer_t;

    // zero history: trailing zero count, or prefix complete
    typedef enum logic [1:0] {
        ZR_NONE = 2'd0,
        ZR_ONE  = 2'd1,
        ZR_TWO  = 2'd2,
        ZR_CODE = 2'd3
    } zero_run_t;

    // code byte values with a class of their own
    localparam logic [7:0] CODE_VO_LAST  = 8'h1F;
    localparam logic [7:0] CODE_VOL_LAST = 8'h2F;
    localparam logic [7:0] CODE_VOS      = 8'hB0;
    localparam logic [7:0] CODE_USER     = 8'hB2;
    localparam logic [7:0] CODE_GOV      = 8'hB3;
    localparam logic [7:0] CODE_VOP      = 8'hB6;

    // result of one scanned byte, handed to the output register
    typedef struct packed {
        logic   hit;
        logic   is_boundary;
        class_t code_class;
    } scan_res_t;

    // map a code byte to its class
    function automatic class_t classify(input logic [7:0] code);
        class_t cls;
        if (code <= CODE_VO_LAST) cls = CLASS_VO;
        else if (code <= CODE_VOL_LAST) cls = CLASS_VOL;
        else if (code == CODE_VOS) cls = CLASS_VOS;
        else if (code == CODE_USER) cls = CLASS_USER;
        else if (code == CODE_GOV) cls = CLASS_GOV;
        else if (code == CODE_VOP) cls = CLASS_VOP;
        else cls = CLASS_OTHER;
        return cls;
    endfunction

endpackage

/* rtl/core/mfbd_in_stage.sv */
// input register stage holding one stream byte
module mfbd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       resync,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_resync
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       resync_reg;

    // take a new item when empty or when the held one moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg   <= data_byte;
            resync_reg <= resync;
        end
    end

    assign held_valid  = valid_reg;
    assign held_byte   = byte_reg;
    assign held_resync = resync_reg;

endmodule

/* rtl/core/mfbd_scan.sv */
// start code scanner: zero history, layer rank and byte offset
module mfbd_scan #(
    parameter int OFFSET_WIDTH = mfbd_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              data_byte,
    input  logic                    resync,
    output mfbd_pkg::scan_res_t     res,
    output logic [OFFSET_WIDTH-1:0] start_offset
);

    mfbd_pkg::zero_run_t      zr_reg, zr_next, zr_cur;
    mfbd_pkg::layer_t         layer_reg, layer_next, layer_cur, code_layer;
    logic [OFFSET_WIDTH-1:0]  pos_reg, pos_next, pos_cur;
    mfbd_pkg::class_t         cls;
    logic                     is_layer;
    logic                     boundary;

    // resync acts as reset ahead of this byte
    assign zr_cur    = resync ? mfbd_pkg::ZR_NONE    : zr_reg;
    assign layer_cur = resync ? mfbd_pkg::LAYER_SYNC : layer_reg;
    assign pos_cur   = resync ? '0 : pos_reg;

    assign cls = mfbd_pkg::classify(data_byte);

    // layer rank of the code class
    always_comb
    begin
        is_layer   = 1'b1;
        code_layer = mfbd_pkg::LAYER_SYNC;
        unique case (cls)
            mfbd_pkg::CLASS_VOS: code_layer = mfbd_pkg::LAYER_VOS;
            mfbd_pkg::CLASS_VO:  code_layer = mfbd_pkg::LAYER_VO;
            mfbd_pkg::CLASS_VOL: code_layer = mfbd_pkg::LAYER_VOL;
            mfbd_pkg::CLASS_GOV: code_layer = mfbd_pkg::LAYER_GOV;
            mfbd_pkg::CLASS_VOP: code_layer = mfbd_pkg::LAYER_VOP;
            default:             is_layer   = 1'b0;
        endcase
    end

    // lower rank, or vop after vop, starts a new frame
    assign boundary = is_layer &&
                      ((code_layer < layer_cur) ||
                       (code_layer == mfbd_pkg::LAYER_VOP &&
                        layer_cur == mfbd_pkg::LAYER_VOP));

    // zero history and layer update
    always_comb
    begin
        layer_next = layer_cur;
        zr_next    = mfbd_pkg::ZR_NONE;
        unique case (zr_cur)
            mfbd_pkg::ZR_CODE:
            begin
                if (is_layer)
                begin
                    layer_next = code_layer;
                end
            end
            mfbd_pkg::ZR_NONE:
            begin
                if (data_byte == 8'h00) zr_next = mfbd_pkg::ZR_ONE;
            end
            mfbd_pkg::ZR_ONE:
            begin
                if (data_byte == 8'h00) zr_next = mfbd_pkg::ZR_TWO;
            end
            mfbd_pkg::ZR_TWO:
            begin
                if (data_byte == 8'h00) zr_next = mfbd_pkg::ZR_TWO;
                else if (data_byte == 8'h01) zr_next = mfbd_pkg::ZR_CODE;
            end
            default: zr_next = mfbd_pkg::ZR_NONE;
        endcase
    end

    assign pos_next = pos_cur + OFFSET_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zr_reg    <= mfbd_pkg::ZR_NONE;
            layer_reg <= mfbd_pkg::LAYER_SYNC;
            pos_reg   <= '0;
        end
        else if (step)
        begin
            zr_reg    <= zr_next;
            layer_reg <= layer_next;
            pos_reg   <= pos_next;
        end
    end

    // result for a code byte
    assign res.hit         = (zr_cur == mfbd_pkg::ZR_CODE);
    assign res.is_boundary = boundary;
    assign res.code_class  = cls;
    assign start_offset    = pos_cur - OFFSET_WIDTH'(3);

endmodule

/* rtl/core/mpeg4_frame_boundary_detector.sv */
// top level of the mpeg-4 part 2 start code frame boundary detector
// Takes one elementary stream byte per item and gives one result item per
// start code (the byte after 00 00 01): its class, whether it opens a new
// frame, and the stream offset of the prefix's first zero byte, cut or
// zero-extended to 32 bits from an OFFSET_WIDTH-bit wrapping counter.
// Bytes that are not code bytes give no result. Throughput is one byte per
// cycle while no held result stalls; an item is held in the input register
// and its result is then registered in the output register.
// The rate is set only by out_ready: a held result stalls the input register.
// resync set on a byte clears all state before that byte is counted.
module mpeg4_frame_boundary_detector #(
    parameter int OFFSET_WIDTH = mfbd_pkg::OFFSET_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        resync,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_boundary,
    output logic [2:0]  code_class,
    output logic [31:0] start_offset
);

    logic                    held_valid;
    logic [7:0]              held_byte;
    logic                    held_resync;
    logic                    advance;
    logic                    out_free;
    mfbd_pkg::scan_res_t     res;
    logic [OFFSET_WIDTH-1:0] scan_offset;
    logic [OFFSET_WIDTH+mfbd_pkg::START_OFFSET_W-1:0] offset_ext;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        boundary_reg;
    logic [2:0]  class_reg;
    logic [31:0] offset_reg;

    // held item moves on when the output register can take its result
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = held_valid && out_free;

    mfbd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .resync      (resync),
        .advance     (advance),
        .held_valid  (held_valid),
        .held_byte   (held_byte),
        .held_resync (held_resync)
    );

    mfbd_scan #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (held_byte),
        .resync       (held_resync),
        .res          (res),
        .start_offset (scan_offset)
    );

    // fit the counter width to the 32-bit field
    assign offset_ext = {{mfbd_pkg::START_OFFSET_W{1'b0}}, scan_offset};

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (advance && res.hit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.hit)
        begin
            boundary_reg <= res.is_boundary;
            class_reg    <= res.code_class;
            offset_reg   <= offset_ext[mfbd_pkg::START_OFFSET_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_boundary  = boundary_reg;
    assign code_class   = class_reg;
    assign start_offset = offset_reg;

endmodule

/* tb/frame_boundary_checker.sv */
// watches both channels of the frame boundary detector and checks every result item
module frame_boundary_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        resync,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        is_boundary,
    input  logic [2:0]  code_class,
    input  logic [31:0] start_offset,
    output int          mismatches,
    output int          codes_due
);

    // prefix bytes and length
    localparam logic [7:0]  ZERO_BYTE  = 8'h00;
    localparam logic [7:0]  PREFIX_END = 8'h01;
    localparam logic [31:0] PREFIX_LEN = 32'd3;
    // rank of classes that leave the layer alone
    localparam logic [2:0]  NO_RANK    = 3'd0;

    typedef struct packed {
        logic             boundary;
        mfbd_pkg::class_t cls;
        logic [31:0]      offset;
    } start_code_t;

    // predicted detector state
    mfbd_pkg::zero_run_t zero_hist;
    mfbd_pkg::layer_t    kept_layer;
    logic [31:0]         stream_pos;

    start_code_t start_codes_due[$];
    start_code_t want;
    int          errs = 0;

    // class of the byte that follows a complete prefix
    function automatic mfbd_pkg::class_t class_of_code(input logic [7:0] code);
        // video object codes fill 00..1f, object layer codes 20..2f
        if (code[7:5] == 3'b000)
            return mfbd_pkg::CLASS_VO;
        if (code[7:4] == 4'h2)
            return mfbd_pkg::CLASS_VOL;
        case (code)
            mfbd_pkg::CODE_VOS:  return mfbd_pkg::CLASS_VOS;
            mfbd_pkg::CODE_USER: return mfbd_pkg::CLASS_USER;
            mfbd_pkg::CODE_GOV:  return mfbd_pkg::CLASS_GOV;
            mfbd_pkg::CODE_VOP:  return mfbd_pkg::CLASS_VOP;
            default:             return mfbd_pkg::CLASS_OTHER;
        endcase
    endfunction

    // header layer rank of a class, none for user data and other codes
    function automatic logic [2:0] rank_of(input mfbd_pkg::class_t cls);
        case (cls)
            mfbd_pkg::CLASS_VOS: return mfbd_pkg::LAYER_VOS;
            mfbd_pkg::CLASS_VO:  return mfbd_pkg::LAYER_VO;
            mfbd_pkg::CLASS_VOL: return mfbd_pkg::LAYER_VOL;
            mfbd_pkg::CLASS_GOV: return mfbd_pkg::LAYER_GOV;
            mfbd_pkg::CLASS_VOP: return mfbd_pkg::LAYER_VOP;
            default:             return NO_RANK;
        endcase
    endfunction

    // advance the predicted state by one stream byte, queue a start code if one ends here
    task automatic scan_stream_byte(input logic [7:0] b, input logic sync);
        start_code_t hit;
        logic [2:0]  rank;
        if (sync)
        begin
            zero_hist  = mfbd_pkg::ZR_NONE;
            kept_layer = mfbd_pkg::LAYER_SYNC;
            stream_pos = '0;
        end
        if (zero_hist == mfbd_pkg::ZR_CODE)
        begin
            hit.cls      = class_of_code(b);
            rank         = rank_of(hit.cls);
            hit.boundary = 1'b0;
            if (rank != NO_RANK)
            begin
                // lower layer, or picture after picture, opens a frame
                hit.boundary = (rank < kept_layer) ||
                               (rank == mfbd_pkg::LAYER_VOP &&
                                kept_layer == mfbd_pkg::LAYER_VOP);
                kept_layer   = mfbd_pkg::layer_t'(rank);
            end
            hit.offset = stream_pos - PREFIX_LEN;
            start_codes_due.push_back(hit);
            zero_hist = mfbd_pkg::ZR_NONE;
        end
        else if (b == ZERO_BYTE)
        begin
            if (zero_hist != mfbd_pkg::ZR_TWO)
                zero_hist = mfbd_pkg::zero_run_t'(zero_hist + 2'd1);
        end
        else if (b == PREFIX_END && zero_hist == mfbd_pkg::ZR_TWO)
            zero_hist = mfbd_pkg::ZR_CODE;
        else
            zero_hist = mfbd_pkg::ZR_NONE;
        stream_pos = stream_pos + 32'd1;
    endtask

    // predict on accepted input items, compare accepted result items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_hist  = mfbd_pkg::ZR_NONE;
            kept_layer = mfbd_pkg::LAYER_SYNC;
            stream_pos = '0;
            start_codes_due.delete();
            codes_due  <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                scan_stream_byte(data_byte, resync);
            if (out_valid && out_ready)
            begin
                if (start_codes_due.size() == 0)
                begin
                    $error("result item with no start code pending: class %0d offset 0x%08h",
                           code_class, start_offset);
                    errs++;
                end
                else
                begin
                    want = start_codes_due.pop_front();
                    if (is_boundary !== want.boundary)
                    begin
                        $error("is_boundary: expected %0b, actual %0b",
                               want.boundary, is_boundary);
                        errs++;
                    end
                    if (code_class !== want.cls)
                    begin
                        $error("code_class: expected %0d, actual %0d", want.cls, code_class);
                        errs++;
                    end
                    if (start_offset !== want.offset)
                    begin
                        $error("start_offset: expected 0x%08h, actual 0x%08h",
                               want.offset, start_offset);
                        errs++;
                    end
                end
            end
            codes_due  <= start_codes_due.size();
            mismatches <= errs;
        end
    end

endmodule

/* tb/tb.sv */
// stimulus and verdict for the mpeg-4 frame boundary detector
module tb;

    localparam logic [7:0] ZERO_BYTE       = 8'h00;
    localparam logic [7:0] PREFIX_END      = 8'h01;
    localparam int         STREAM_ITEMS    = 1950;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         DRAIN_CYCLES    = 12;
    localparam int         CYCLE_LIMIT     = 400000;

    typedef struct {
        logic [7:0] b;
        logic       sync;
    } stream_item_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        resync    = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        is_boundary;
    logic [2:0]  code_class;
    logic [31:0] start_offset;

    int           mismatches;
    int           codes_due;
    int           cycle_count = 0;
    stream_item_t stream[$];

    mpeg4_frame_boundary_detector i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .resync       (resync),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_boundary  (is_boundary),
        .code_class   (code_class),
        .start_offset (start_offset)
    );

    frame_boundary_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .resync       (resync),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_boundary  (is_boundary),
        .code_class   (code_class),
        .start_offset (start_offset),
        .mismatches   (mismatches),
        .codes_due    (codes_due)
    );

    // 10 unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reset at start of simulation, once
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic sync);
        stream_item_t it;
        it.b    = b;
        it.sync = sync;
        stream.push_back(it);
    endtask

    // zero run, prefix end and code byte; resync may ride on the first zero
    task automatic add_start_code(input int zeros, input logic [7:0] code, input logic sync);
        for (int i = 0; i < zeros; i++)
            add_byte(ZERO_BYTE, sync && i == 0);
        add_byte(PREFIX_END, 1'b0);
        add_byte(code, 1'b0);
    endtask

    // code byte weighted toward pictures
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 9))
            0:       return mfbd_pkg::CODE_VOS;
            1:       return 8'($urandom_range(0, 31));
            2:       return 8'($urandom_range(32, 47));
            3:       return mfbd_pkg::CODE_GOV;
            4, 5, 6: return mfbd_pkg::CODE_VOP;
            7:       return mfbd_pkg::CODE_USER;
            8:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(48, 255));
        endcase
    endfunction

    // build the stream, then offer it in bursts
    initial
    begin
        int burst_left;
        int gap;
        int pick;
        int n;

        // directed: vos, vo, picture after picture, user data, long zeros, other codes
        add_start_code(2, mfbd_pkg::CODE_VOS, 1'b0);
        add_start_code(2, ZERO_BYTE, 1'b0);
        // zero code byte must not start a new prefix
        add_byte(ZERO_BYTE, 1'b0);
        add_byte(PREFIX_END, 1'b0);
        add_start_code(2, mfbd_pkg::CODE_VOP, 1'b1);
        add_start_code(2, mfbd_pkg::CODE_VOP, 1'b0);
        add_start_code(3, mfbd_pkg::CODE_USER, 1'b0);
        add_start_code(2, 8'hFF, 1'b0);

        // random: mostly well-formed start codes with payload, some broken, some noise
        while (stream.size() < STREAM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                add_start_code(($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 2,
                               pick_code(), $urandom_range(0, 39) == 0);
                n = $urandom_range(0, 10);
                repeat (n) add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick < 90)
            begin
                n = $urandom_range(1, 2);
                for (int i = 0; i < n; i++)
                    add_byte(ZERO_BYTE, i == 0 && $urandom_range(0, 7) == 0);
                add_byte(8'($urandom_range(1, 255)), 1'b0);
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
        end

        do @(posedge clk); while (!rst_n);

        burst_left = 0;
        foreach (stream[k])
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            in_valid  <= 1'b1;
            data_byte <= stream[k].b;
            resync    <= stream[k].sync;
            do @(posedge clk); while (!in_ready);
            burst_left--;
        end
        in_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (codes_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // receiver: segments of free flow and random stalls, one long hold-off
    initial
    begin
        int seg;
        int pct;
        int len;
        seg = 0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (seg == 4)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(25, 90);
            len = $urandom_range(10, 150);
            repeat (len)
            begin
                out_ready <= ($urandom_range(1, 100) <= pct);
                @(posedge clk);
            end
            seg++;
        end
    end

endmodule
